>>> rtl/mbsp_pkg.sv
`default_nettype none

package mbsp_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

    localparam logic [2:0] EV_ACCEPT  = 3'd0;
    localparam logic [2:0] EV_CHANNEL = 3'd1;
    localparam logic [2:0] EV_COMMON  = 3'd2;
    localparam logic [2:0] EV_REALT   = 3'd3;
    localparam logic [2:0] EV_SYSEX   = 3'd4;
    localparam logic [2:0] EV_ERROR   = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_STATUS    = 2'd1;
    localparam logic [1:0] ERR_UNEXP     = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_COMMON = 4'd8;
    localparam logic [3:0] ST_SYSEX  = 4'd9;

    localparam logic [1:0] M_RUN  = 2'd0;
    localparam logic [1:0] M_RD   = 2'd1;
    localparam logic [1:0] M_SEND = 2'd2;

    localparam logic [7:0] B_SYSEX_START = 8'hF0;
    localparam logic [7:0] B_TC          = 8'hF1;
    localparam logic [7:0] B_SONG_POS    = 8'hF2;
    localparam logic [7:0] B_SONG_SEL    = 8'hF3;
    localparam logic [7:0] B_TUNE        = 8'hF6;
    localparam logic [7:0] B_SYSEX_END   = 8'hF7;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [5:0] message_length;
        logic [1:0] error_code;
        logic [3:0] error_state;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/mbsp_ram.sv
`default_nettype none

module mbsp_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/midi_byte_stream_parser.sv
// MIDI byte stream parser, no running status.
// Request channel midi_valid/midi_ready carries one raw byte per request.
// Result channel event_valid/event_ready carries one parsed result per request.
// Each byte gives one result, except a sysex end byte, which gives the whole
// buffered sysex run (F0 through F7), one byte per result, last set on the
// final one. A result is registered in the cycle after its byte is taken; bytes are
// taken one per cycle while results are being drained on the other side.
// A sysex run is read back from the buffer memory in two steps per byte
// (read, then load into the result register); no byte is taken meanwhile.
// The result register acts as the output stage: a new byte is taken while a
// result waits, provided event_ready frees the register in that same cycle.
// When the receiver stalls, the result holds and midi_ready drops.
// Reset leaves the parser idle with no result pending; the sysex buffer
// is not cleared and needs no clearing pass.
`default_nettype none

module midi_byte_stream_parser
    import mbsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       midi_valid,
    output logic            midi_ready,
    input  wire logic [7:0] midi_byte,
    output logic            event_valid,
    input  wire logic       event_ready,
    output logic [2:0]      event_res,
    output logic [7:0]      status_byte,
    output logic [6:0]      first_data,
    output logic [6:0]      second_data,
    output logic [5:0]      message_length,
    output logic [1:0]      error_code,
    output logic [3:0]      error_state,
    output logic            last
);

    logic [1:0]       mode_reg, mode_next;
    logic [3:0]       pstate_reg, pstate_next;
    logic [1:0]       exp_len_reg, exp_len_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       stat_reg, stat_next;
    logic [6:0]       d1_reg, d1_next;
    logic [BUF_AW-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] drain_len_reg, drain_len_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic             wr_en;
    logic [BUF_AW-1:0] wr_addr;
    logic             rd_en;
    logic [7:0]       rd_data;

    logic             slot_free;
    logic             take;
    logic             emit;
    logic             is_status;
    logic [2:0]       kind;
    result_t          res;

    mbsp_ram #(
        .DEPTH (BUFFER_BYTES),
        .WIDTH (8)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (midi_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign slot_free  = !out_valid_reg || event_ready;
    assign midi_ready = (mode_reg == M_RUN) && slot_free;
    assign take       = midi_valid && midi_ready;
    assign is_status  = midi_byte[7];
    assign kind       = midi_byte[6:4];

    always_comb
    begin
        mode_next      = mode_reg;
        pstate_next    = pstate_reg;
        exp_len_next   = exp_len_reg;
        count_next     = count_reg;
        stat_next      = stat_reg;
        d1_next        = d1_reg;
        rd_idx_next    = rd_idx_reg;
        drain_len_next = drain_len_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[BUF_AW-1:0];
        rd_en          = 1'b0;
        emit           = 1'b0;
        res            = '0;
        res.last       = 1'b1;

        case (mode_reg)
            M_RUN:
            begin
                if (take)
                begin
                    emit = 1'b1;
                    if (is_status && midi_byte > B_SYSEX_END)
                    begin
                        res.event_res      = EV_REALT;
                        res.status_byte    = midi_byte;
                        res.message_length = 6'd1;
                    end
                    else if (pstate_reg == ST_IDLE)
                    begin
                        if (!is_status)
                        begin
                            res.event_res   = EV_ERROR;
                            res.status_byte = midi_byte;
                            res.error_code  = ERR_STATUS;
                            res.error_state = ST_IDLE;
                        end
                        else if (midi_byte < B_SYSEX_START)
                        begin
                            pstate_next  = {1'b0, kind} + 4'd1;
                            exp_len_next = (kind == 3'd4 || kind == 3'd5) ? 2'd2 : 2'd3;
                            count_next   = CNT_W'(1);
                            stat_next    = midi_byte;
                        end
                        else if (midi_byte == B_SYSEX_START)
                        begin
                            pstate_next = ST_SYSEX;
                            count_next  = CNT_W'(1);
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                        end
                        else if (midi_byte == B_TC || midi_byte == B_SONG_SEL)
                        begin
                            pstate_next  = ST_COMMON;
                            exp_len_next = 2'd2;
                            count_next   = CNT_W'(1);
                            stat_next    = midi_byte;
                        end
                        else if (midi_byte == B_SONG_POS)
                        begin
                            pstate_next  = ST_COMMON;
                            exp_len_next = 2'd3;
                            count_next   = CNT_W'(1);
                            stat_next    = midi_byte;
                        end
                        else if (midi_byte == B_TUNE)
                        begin
                            res.event_res      = EV_COMMON;
                            res.status_byte    = midi_byte;
                            res.message_length = 6'd1;
                        end
                        else
                        begin
                            res.event_res   = EV_ERROR;
                            res.status_byte = midi_byte;
                            res.error_code  = ERR_UNEXP;
                            res.error_state = ST_IDLE;
                        end
                    end
                    else if (pstate_reg == ST_SYSEX)
                    begin
                        if (is_status && midi_byte != B_SYSEX_END)
                        begin
                            res.event_res   = EV_ERROR;
                            res.status_byte = midi_byte;
                            res.error_code  = ERR_STATUS;
                            res.error_state = ST_SYSEX;
                            pstate_next     = ST_IDLE;
                            count_next      = '0;
                        end
                        else if (count_reg >= CNT_W'(BUFFER_BYTES))
                        begin
                            res.event_res   = EV_ERROR;
                            res.status_byte = midi_byte;
                            res.error_code  = ERR_OVERFLOW;
                            res.error_state = ST_SYSEX;
                            pstate_next     = ST_IDLE;
                            count_next      = '0;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            if (midi_byte == B_SYSEX_END)
                            begin
                                emit           = 1'b0;
                                mode_next      = M_RD;
                                rd_idx_next    = '0;
                                drain_len_next = count_reg + CNT_W'(1);
                                pstate_next    = ST_IDLE;
                                count_next     = '0;
                            end
                        end
                    end
                    else if (pstate_reg > ST_SYSEX)
                    begin
                        pstate_next = ST_IDLE;
                        count_next  = '0;
                    end
                    else if (is_status)
                    begin
                        res.event_res   = EV_ERROR;
                        res.status_byte = midi_byte;
                        res.error_code  = ERR_UNEXP;
                        res.error_state = pstate_reg;
                        pstate_next     = ST_IDLE;
                        count_next      = '0;
                    end
                    else if (count_reg == CNT_W'(1) && exp_len_reg == 2'd3)
                    begin
                        d1_next    = midi_byte[6:0];
                        count_next = CNT_W'(2);
                    end
                    else
                    begin
                        res.event_res      = (pstate_reg == ST_COMMON) ? EV_COMMON : EV_CHANNEL;
                        res.status_byte    = stat_reg;
                        res.message_length = {4'd0, exp_len_reg};
                        if (exp_len_reg == 2'd3)
                        begin
                            res.first_data  = d1_reg;
                            res.second_data = midi_byte[6:0];
                        end
                        else
                        begin
                            res.first_data = midi_byte[6:0];
                        end
                        pstate_next = ST_IDLE;
                        count_next  = '0;
                    end
                end
            end
            M_RD:
            begin
                rd_en     = 1'b1;
                mode_next = M_SEND;
            end
            M_SEND:
            begin
                res.event_res      = EV_SYSEX;
                res.status_byte    = rd_data;
                res.message_length = 6'(drain_len_reg);
                res.last           = (CNT_W'(rd_idx_reg) + CNT_W'(1)) == drain_len_reg;
                if (slot_free)
                begin
                    emit        = 1'b1;
                    rd_idx_next = rd_idx_reg + BUF_AW'(1);
                    mode_next   = res.last ? M_RUN : M_RD;
                end
            end
            default:
            begin
                mode_next = M_RUN;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            res_next       = res;
        end
        else
        begin
            out_valid_next = out_valid_reg && !event_ready;
            res_next       = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_RUN;
            pstate_reg    <= ST_IDLE;
            exp_len_reg   <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            drain_len_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            pstate_reg    <= pstate_next;
            exp_len_reg   <= exp_len_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            drain_len_reg <= drain_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        d1_reg   <= d1_next;
        res_reg  <= res_next;
    end

    assign event_valid    = out_valid_reg;
    assign event_res      = res_reg.event_res;
    assign status_byte    = res_reg.status_byte;
    assign first_data     = res_reg.first_data;
    assign second_data    = res_reg.second_data;
    assign message_length = res_reg.message_length;
    assign error_code     = res_reg.error_code;
    assign error_state    = res_reg.error_state;
    assign last           = res_reg.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BUFFER_BYTES))
        else $error("byte count past buffer size");

    a_drain_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_RUN) |-> (drain_len_reg >= CNT_W'(2)
                                 && drain_len_reg <= CNT_W'(BUFFER_BYTES)))
        else $error("sysex run length out of range");

    a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_RUN) |-> (CNT_W'(rd_idx_reg) < drain_len_reg))
        else $error("drain index past run");

    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_RUN) |-> (pstate_reg == ST_IDLE && count_reg == '0))
        else $error("parser not cleared during sysex drain");

    a_last_sysex: assert property (@(posedge clk) disable iff (!rst_n)
        (event_valid && !last) |-> (event_res == EV_SYSEX))
        else $error("non-final result outside sysex run");

endmodule

`default_nettype wire

>>> verif/midi_parse_checker.sv
`default_nettype none

module midi_parse_checker
    import mbsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       midi_valid,
    input  wire logic       midi_ready,
    input  wire logic [7:0] midi_byte,
    input  wire logic       event_valid,
    input  wire logic       event_ready,
    input  wire logic [2:0] event_res,
    input  wire logic [7:0] status_byte,
    input  wire logic [6:0] first_data,
    input  wire logic [6:0] second_data,
    input  wire logic [5:0] message_length,
    input  wire logic [1:0] error_code,
    input  wire logic [3:0] error_state,
    input  wire logic       last,
    output int              mismatches,
    output int              outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] B_REALTIME_MIN = 8'hF8;

    logic [3:0] parser_state = ST_IDLE;
    logic [5:0] msg_len      = '0;
    logic [5:0] byte_cnt     = '0;
    logic [7:0] msg_bytes [BUFFER_BYTES];

    result_t    pending_results [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic queue_result(input logic [2:0] ev, input logic [7:0] st,
                                input logic [6:0] d1, input logic [6:0] d2,
                                input logic [5:0] len, input logic [1:0] ec,
                                input logic [3:0] es, input logic lst);
        result_t r;
        r.event_res      = ev;
        r.status_byte    = st;
        r.first_data     = d1;
        r.second_data    = d2;
        r.message_length = len;
        r.error_code     = ec;
        r.error_state    = es;
        r.last           = lst;
        pending_results.push_back(r);
    endtask

    task automatic idle_parser();
        parser_state = ST_IDLE;
        msg_len      = '0;
        byte_cnt     = '0;
    endtask

    task automatic flag_error(input logic [1:0] code, input logic [7:0] b);
        queue_result(EV_ERROR, b, '0, '0, '0, code, parser_state, 1'b1);
        idle_parser();
    endtask

    task automatic buffer_byte(input logic [7:0] b);
        if (byte_cnt < BUFFER_BYTES)
        begin
            msg_bytes[byte_cnt] = b;
            byte_cnt++;
        end
    endtask

    task automatic start_message(input logic [3:0] st, input logic [5:0] len,
                                 input logic [7:0] b);
        parser_state = st;
        msg_len      = len;
        byte_cnt     = '0;
        buffer_byte(b);
        queue_result(EV_ACCEPT, '0, '0, '0, '0, ERR_NONE, ST_IDLE, 1'b1);
    endtask

    // Expected results of one accepted MIDI byte.
    task automatic parse_byte(input logic [7:0] b);
        logic [2:0] kind;
        logic [2:0] ev;
        logic [6:0] d2;
        kind = b[6:4];
        if (b >= B_REALTIME_MIN)
            queue_result(EV_REALT, b, '0, '0, 6'd1, ERR_NONE, ST_IDLE, 1'b1);
        else if (parser_state == ST_IDLE)
        begin
            if (!b[7])
                flag_error(ERR_STATUS, b);
            else if (b < B_SYSEX_START)
                start_message({1'b0, kind} + 4'd1,
                              (kind == 3'd4 || kind == 3'd5) ? 6'd2 : 6'd3, b);
            else
            begin
                case (b)
                    B_SYSEX_START: start_message(ST_SYSEX, 6'd1, b);
                    B_TC:          start_message(ST_COMMON, 6'd2, b);
                    B_SONG_POS:    start_message(ST_COMMON, 6'd3, b);
                    B_SONG_SEL:    start_message(ST_COMMON, 6'd2, b);
                    B_TUNE:
                        queue_result(EV_COMMON, b, '0, '0, 6'd1, ERR_NONE, ST_IDLE, 1'b1);
                    default:       flag_error(ERR_UNEXP, b);
                endcase
            end
        end
        else if (parser_state == ST_SYSEX)
        begin
            if (b[7] && b != B_SYSEX_END)
                flag_error(ERR_STATUS, b);
            else if (byte_cnt >= BUFFER_BYTES)
                flag_error(ERR_OVERFLOW, b);
            else
            begin
                buffer_byte(b);
                if (b == B_SYSEX_END)
                begin
                    for (int i = 0; i < byte_cnt; i++)
                        queue_result(EV_SYSEX, msg_bytes[i], '0, '0, byte_cnt,
                                     ERR_NONE, ST_IDLE, i == byte_cnt - 1);
                    idle_parser();
                end
                else
                    queue_result(EV_ACCEPT, '0, '0, '0, '0, ERR_NONE, ST_IDLE, 1'b1);
            end
        end
        else
        begin
            if (b[7])
                flag_error(ERR_UNEXP, b);
            else if (byte_cnt >= msg_len)
                flag_error(ERR_OVERFLOW, b);
            else
            begin
                buffer_byte(b);
                if (byte_cnt == msg_len)
                begin
                    ev = (parser_state == ST_COMMON) ? EV_COMMON : EV_CHANNEL;
                    d2 = (msg_len >= 6'd3) ? msg_bytes[2][6:0] : 7'd0;
                    queue_result(ev, msg_bytes[0], msg_bytes[1][6:0], d2, msg_len,
                                 ERR_NONE, ST_IDLE, 1'b1);
                    idle_parser();
                end
                else
                    queue_result(EV_ACCEPT, '0, '0, '0, '0, ERR_NONE, ST_IDLE, 1'b1);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t ns: unexpected result, actual event_res %0d status 0x%0h",
                     $time, event_res, status_byte);
            mismatches++;
        end
        else
        begin
            want = pending_results.pop_front();
            check_field("event_res", want.event_res, event_res);
            check_field("status_byte", want.status_byte, status_byte);
            check_field("first_data", want.first_data, first_data);
            check_field("second_data", want.second_data, second_data);
            check_field("message_length", want.message_length, message_length);
            check_field("error_code", want.error_code, error_code);
            check_field("error_state", want.error_state, error_state);
            check_field("last", want.last, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_parser();
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (event_valid && event_ready)
                check_result();
            if (midi_valid && midi_ready)
                parse_byte(midi_byte);
            outstanding = pending_results.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/midi_byte_stream_parser_tb.sv
`default_nettype none

module midi_byte_stream_parser_tb
    import mbsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 160;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic [7:0] B_UNDEF_F4     = 8'hF4;
    localparam logic [7:0] B_UNDEF_F5     = 8'hF5;
    localparam logic [7:0] B_CLOCK        = 8'hF8;
    localparam logic [7:0] B_ACTIVE_SENSE = 8'hFE;
    localparam logic [7:0] B_SYS_RESET    = 8'hFF;
    localparam logic [7:0] NOTE_ON        = 8'h90;
    localparam logic [7:0] CTRL_CHANGE    = 8'hB0;
    localparam logic [7:0] PROG_CHANGE    = 8'hC0;
    localparam logic [7:0] PITCH_BEND     = 8'hE0;

    localparam logic [7:0] DIRECTED [26] = '{
        8'h00, 8'h7F, B_UNDEF_F4, B_UNDEF_F5, B_SYSEX_END, B_CLOCK, B_SYS_RESET,
        PROG_CHANGE | 8'h05, B_ACTIVE_SENSE, 8'h7F,
        NOTE_ON, 8'h7F, 8'h00,
        CTRL_CHANGE, B_SONG_POS,
        B_TC, 8'h55,
        B_SONG_POS, 8'h01, 8'h7F,
        B_TUNE,
        B_SYSEX_START, 8'h01, B_SYSEX_END,
        B_SYSEX_START, PITCH_BEND
    };

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       midi_valid  = 1'b0;
    logic [7:0] midi_byte   = 8'h00;
    logic       event_ready = 1'b0;
    logic       midi_ready;
    logic       event_valid;
    logic [2:0] event_res;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic [5:0] message_length;
    logic [1:0] error_code;
    logic [3:0] error_state;
    logic       last;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int bytes_sent  = 0;
    int burst_left  = 0;
    logic hold_req  = 1'b0;

    int   rx_cycle  = 0;
    int   rx_mode   = 0;
    int   hold_left = 0;
    logic hold_seen = 1'b0;

    always #6 clk = ~clk;

    midi_byte_stream_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .midi_valid     (midi_valid),
        .midi_ready     (midi_ready),
        .midi_byte      (midi_byte),
        .event_valid    (event_valid),
        .event_ready    (event_ready),
        .event_res      (event_res),
        .status_byte    (status_byte),
        .first_data     (first_data),
        .second_data    (second_data),
        .message_length (message_length),
        .error_code     (error_code),
        .error_state    (error_state),
        .last           (last)
    );

    midi_parse_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .midi_valid     (midi_valid),
        .midi_ready     (midi_ready),
        .midi_byte      (midi_byte),
        .event_valid    (event_valid),
        .event_ready    (event_ready),
        .event_res      (event_res),
        .status_byte    (status_byte),
        .first_data     (first_data),
        .second_data    (second_data),
        .message_length (message_length),
        .error_code     (error_code),
        .error_state    (error_state),
        .last           (last),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: changing stall pattern, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 80 == 0)
                rx_mode = $urandom_range(0, 3);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                event_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       event_ready <= 1'b1;
                    1:       event_ready <= $urandom_range(0, 1);
                    2:       event_ready <= ($urandom_range(0, 3) == 0);
                    default: event_ready <= (rx_cycle % 5) < 2;
                endcase
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                midi_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        midi_valid <= 1'b1;
        midi_byte  <= b;
        @(posedge clk);
        while (!midi_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_data();
        return 8'($urandom_range(0, 127));
    endfunction

    // data byte, now and then preceded by a realtime byte
    task automatic put_data(input logic [7:0] b);
        if ($urandom_range(0, 7) == 0)
            put_byte(8'($urandom_range(B_CLOCK, B_SYS_RESET)));
        put_byte(b);
    endtask

    task automatic drain();
        @(negedge clk);
        midi_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        burst_left = 0;
    endtask

    task automatic send_random_message();
        int pick;
        int n;
        logic [7:0] st;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
            put_byte(st);
            n = (st[6:4] == 3'd4 || st[6:4] == 3'd5) ? 1 : 2;
            repeat (n) put_data(rand_data());
        end
        else if (pick < 42)
        begin
            st = 8'($urandom_range(B_TC, B_SONG_SEL));
            put_byte(st);
            n = (st == B_SONG_POS) ? 2 : 1;
            repeat (n) put_data(rand_data());
        end
        else if (pick < 48)
            put_byte($urandom_range(0, 1) ? B_TUNE : 8'($urandom_range(B_CLOCK, B_SYS_RESET)));
        else if (pick < 63)
        begin
            n = ($urandom_range(0, 7) == 0) ? BUFFER_BYTES - 2 : $urandom_range(0, 6);
            put_byte(B_SYSEX_START);
            repeat (n) put_data(rand_data());
            put_byte(B_SYSEX_END);
        end
        else if (pick < 67)
        begin
            // one byte past the buffer
            put_byte(B_SYSEX_START);
            repeat (BUFFER_BYTES - 1) put_byte(rand_data());
            put_byte($urandom_range(0, 1) ? B_SYSEX_END : rand_data());
        end
        else if (pick < 82)
        begin
            // message that a status byte may cut short
            case ($urandom_range(0, 3))
                0:       st = B_SYSEX_START;
                1:       st = 8'($urandom_range(B_TC, B_SONG_SEL));
                default: st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
            endcase
            put_byte(st);
            if ($urandom_range(0, 1))
                put_data(rand_data());
            put_byte(8'($urandom_range(8'h80, B_SYSEX_END)));
        end
        else
            put_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int start;
        logic held;
        logic paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        foreach (DIRECTED[i])
            put_byte(DIRECTED[i]);
        drain();
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (!held && bytes_sent - start >= 40)
            begin
                hold_req = ~hold_req;
                held     = 1'b1;
            end
            if (!paused && bytes_sent - start >= 100)
            begin
                drain();
                paused = 1'b1;
            end
            send_random_message();
        end
        drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> midi_byte_stream_parser.f
rtl/mbsp_pkg.sv
rtl/mbsp_ram.sv
rtl/midi_byte_stream_parser.sv
verif/midi_parse_checker.sv
verif/midi_byte_stream_parser_tb.sv
